### rtl/moving_harmonic_restraint_defines.svh
// Assertion macros for the restraint block
`ifndef MOVING_HARMONIC_RESTRAINT_DEFINES_SVH
`define MOVING_HARMONIC_RESTRAINT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define MHR_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define MHR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mhr_pkg.sv
package mhr_pkg;

  localparam int MAX_POINTS = 16;
  localparam int MAX_ARGS   = 8;
  localparam int FRAC_BITS  = 16;
  localparam int PT_W       = 4;
  localparam int ARG_W      = 3;
  localparam int TBL_W      = PT_W + ARG_W;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Configuration register indexes
  localparam logic CFG_NUM_POINTS = 1'b0;
  localparam logic CFG_SIDE_MODES = 1'b1;

  // Side modes
  localparam logic [1:0] SIDE_UPPER = 2'd1;
  localparam logic [1:0] SIDE_LOWER = 2'd2;

  typedef struct packed {
    logic                is_eval;
    logic [PT_W-1:0]     point_index;
    logic [ARG_W-1:0]    arg_index;
    logic [31:0]         step_value;
    logic signed [31:0]  kappa_value;
    logic signed [31:0]  center_value;
    logic signed [31:0]  arg_value;
    logic                last_arg;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic pop;
    logic res_load;
  } back_stat_t;

endpackage

### rtl/moving_harmonic_restraint.sv
// Channel  Handshake                Payload
// in       in_valid / in_stall      op, point_index, arg_index, step_value,
//                                   kappa_value, center_value, arg_value, last_arg
// out      out_valid / out_stall    force_res, applied, bias_energy,
//                                   force_squared_sum, totals_final
// cfg      cfg_we                   cfg_index, cfg_data
//
// A load item is written to the schedule memories when it is popped; an evaluate item
// runs the point search, then, when it falls between two points, the 16-step fraction
// divider and the blend, then the force, energy and force-squared terms, all products on
// the shared 33x33 multiplier; the side mode can skip the force and the sums.
// Reset (rst, synchronous) empties the two-entry input queue and clears sums.
// Input is stalled only while the queue is full; a held result stalls the back end.
`include "moving_harmonic_restraint_defines.svh"

module moving_harmonic_restraint (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                op,
  input  logic [3:0]          point_index,
  input  logic [2:0]          arg_index,
  input  logic [31:0]         step_value,
  input  logic signed [31:0]  kappa_value,
  input  logic signed [31:0]  center_value,
  input  logic signed [31:0]  arg_value,
  input  logic                last_arg,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [47:0]  force_res,
  output logic                applied,
  output logic signed [63:0]  bias_energy,
  output logic [63:0]         force_squared_sum,
  output logic                totals_final
);
  import mhr_pkg::*;

  logic [4:0]  num_points;
  logic [15:0] side_modes;
  head_t       head;
  back_stat_t  stat;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_points <= 5'd1;
      side_modes <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_POINTS: num_points <= cfg_data[4:0];
        CFG_SIDE_MODES: side_modes <= cfg_data;
        default:        num_points <= num_points;
      endcase
    end
  end

  mhr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .point_index  (point_index),
    .arg_index    (arg_index),
    .step_value   (step_value),
    .kappa_value  (kappa_value),
    .center_value (center_value),
    .arg_value    (arg_value),
    .last_arg     (last_arg),
    .pop          (stat.pop),
    .head         (head)
  );

  mhr_back u_back (
    .clk               (clk),
    .rst               (rst),
    .head              (head),
    .num_points        (num_points),
    .side_modes        (side_modes),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .force_res         (force_res),
    .applied           (applied),
    .bias_energy       (bias_energy),
    .force_squared_sum (force_squared_sum),
    .totals_final      (totals_final)
  );

  `MHR_ASSERT_NOW(a_pop_has_item, stat.pop, head.valid, "back end popped an empty queue")
  `MHR_ASSERT_NOW(a_load_free, stat.res_load, (!out_valid || !out_stall), "result overwrote a held transfer")
  `MHR_ASSERT_NXT(a_load_no_result, (stat.pop && !head.item.is_eval), !stat.res_load, "load item produced a result")

endmodule

### rtl/mhr_front.sv
module mhr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                op,
  input  logic [3:0]          point_index,
  input  logic [2:0]          arg_index,
  input  logic [31:0]         step_value,
  input  logic signed [31:0]  kappa_value,
  input  logic signed [31:0]  center_value,
  input  logic signed [31:0]  arg_value,
  input  logic                last_arg,
  input  logic                pop,
  output mhr_pkg::head_t      head
);
  import mhr_pkg::*;

  item_t       entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        take;
  item_t       item_in;

  // Classify the incoming item and pack it
  always_comb begin
    item_in.is_eval      = (op == OP_EVAL);
    item_in.point_index  = point_index;
    item_in.arg_index    = arg_index;
    item_in.step_value   = step_value;
    item_in.kappa_value  = kappa_value;
    item_in.center_value = center_value;
    item_in.arg_value    = arg_value;
    item_in.last_arg     = last_arg;
  end

  assign in_stall   = (count == 2'd2);
  assign push       = in_valid && !in_stall;
  assign take       = pop && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.item  = entries[rd_ptr];

  // Hold payload in the queue
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (take) rd_ptr <= !rd_ptr;
      case ({push, take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/mhr_back.sv
module mhr_back (
  input  logic                clk,
  input  logic                rst,
  input  mhr_pkg::head_t      head,
  input  logic [4:0]          num_points,
  input  logic [15:0]         side_modes,
  output mhr_pkg::back_stat_t stat,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [47:0]  force_res,
  output logic                applied,
  output logic signed [63:0]  bias_energy,
  output logic [63:0]         force_squared_sum,
  output logic                totals_final
);
  import mhr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_P0, S_PN, S_SA, S_SC, S_DIV, S_TA, S_TB, S_TC,
    S_B1, S_B2, S_B3, S_B4, S_B5, S_TCL, S_TCL2, S_OFF,
    S_F0, S_F1, S_F2, S_E0, S_E1, S_E2, S_E3, S_Q1, S_Q2, S_Q3, S_OUT
  } state_t;

  state_t state;

  // Schedule storage
  logic [31:0]        ps_mem [MAX_POINTS];
  logic signed [31:0] kt_mem [MAX_POINTS*MAX_ARGS];
  logic signed [31:0] ct_mem [MAX_POINTS*MAX_ARGS];
  logic [31:0]        ps_rd;
  logic signed [31:0] k_rd;
  logic signed [31:0] c_rd;
  logic [PT_W-1:0]    ps_addr;
  logic [TBL_W-1:0]   tbl_addr;
  logic               wr_load;
  logic [TBL_W-1:0]   wr_addr;

  // Item and work registers
  logic [31:0]        now;
  logic [ARG_W-1:0]   ai;
  logic signed [31:0] argv;
  logic               last;
  logic [PT_W-1:0]    nlast;
  logic [31:0]        prev;
  logic [PT_W-1:0]    idx;
  logic [PT_W-1:0]    pt;
  logic [31:0]        rem;
  logic [31:0]        dvs;
  logic [15:0]        quo;
  logic [3:0]         cnt;
  logic signed [31:0] k0, c0, k1, c1;
  logic signed [48:0] acc;
  logic signed [31:0] kk, aa;
  logic signed [32:0] cv;
  logic               appl;
  logic signed [47:0] frc;
  logic [47:0]        af;
  logic [63:0]        sq;
  logic [63:0]        eplo;
  logic [63:0]        fq0;
  logic [47:0]        fq1;
  logic [96:0]        ftot;
  logic signed [63:0] esum;
  logic [63:0]        fsum;

  // Shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  // Combinational helpers
  logic [4:0]         np_m1;
  logic [PT_W-1:0]    nlast_in;
  logic [32:0]        r2;
  logic               ge;
  logic [16:0]        wc;
  logic signed [49:0] bsum;
  logic signed [66:0] fneg;
  logic signed [50:0] fsh;
  logic signed [47:0] fsat;
  logic [31:0]        acv;
  logic [31:0]        ak;
  logic [1:0]         mode;
  logic               skip;
  logic [96:0]        p_full;
  logic [63:0]        mag_f;
  logic               rem_nz;
  logic [64:0]        mag_n;
  logic signed [63:0] term;
  logic signed [64:0] esum_add;
  logic signed [63:0] esum_next;
  logic [63:0]        fmag;
  logic [64:0]        fsum_add;
  logic [63:0]        fsum_next;
  logic               res_load;
  logic               do_pop;

  assign do_pop   = (state == S_IDLE) && head.valid;
  assign wr_load  = do_pop && !head.item.is_eval;
  assign wr_addr  = {head.item.point_index, head.item.arg_index};
  assign res_load = (state == S_OUT) && (!out_valid || !out_stall);
  assign stat.pop      = do_pop;
  assign stat.res_load = res_load;

  // Clamp the point count to 1..MAX_POINTS
  always_comb begin
    np_m1 = num_points - 5'd1;
    if (num_points == 5'd0) begin
      nlast_in = '0;
    end else if (num_points > 5'(MAX_POINTS)) begin
      nlast_in = PT_W'(MAX_POINTS - 1);
    end else begin
      nlast_in = np_m1[PT_W-1:0];
    end
  end

  // Pick memory read addresses by state
  always_comb begin
    case (state)
      S_P0:    ps_addr = nlast;
      S_SA:    ps_addr = idx;
      default: ps_addr = '0;
    endcase
    case (state)
      S_TA:    tbl_addr = {idx - PT_W'(1), ai};
      S_TB:    tbl_addr = {idx, ai};
      default: tbl_addr = {pt, ai};
    endcase
  end

  // Schedule memories: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_load) begin
      ps_mem[head.item.point_index] <= head.item.step_value;
      kt_mem[wr_addr] <= head.item.kappa_value;
      ct_mem[wr_addr] <= head.item.center_value;
    end
    ps_rd <= ps_mem[ps_addr];
    k_rd  <= kt_mem[tbl_addr];
    c_rd  <= ct_mem[tbl_addr];
  end

  // Select multiplier operands by state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_B1: begin mul_a = 33'(k0); mul_b = {16'b0, wc}; end
      S_B2: begin mul_a = 33'(k1); mul_b = {17'b0, quo}; end
      S_B3: begin mul_a = 33'(c0); mul_b = {16'b0, wc}; end
      S_B4: begin mul_a = 33'(c1); mul_b = {17'b0, quo}; end
      S_F0: begin mul_a = 33'(kk); mul_b = cv; end
      S_F1: begin mul_a = {1'b0, acv}; mul_b = {1'b0, acv}; end
      S_E0: begin mul_a = {1'b0, ak}; mul_b = {1'b0, sq[31:0]}; end
      S_E1: begin mul_a = {1'b0, ak}; mul_b = {1'b0, sq[63:32]}; end
      S_E2: begin mul_a = {1'b0, af[31:0]}; mul_b = {1'b0, af[31:0]}; end
      S_E3: begin mul_a = {1'b0, af[31:0]}; mul_b = {17'b0, af[47:32]}; end
      S_Q1: begin mul_a = {17'b0, af[47:32]}; mul_b = {17'b0, af[47:32]}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // Datapath arithmetic
  always_comb begin
    r2   = {rem, 1'b0};
    ge   = (r2 >= {1'b0, dvs});
    wc   = 17'h10000 - {1'b0, quo};
    bsum = 50'(acc) + 50'(mul_p[48:0]);
    fneg = -67'(mul_p);
    fsh  = fneg[66:16];
    if (fsh > 51'sd140737488355327) begin
      fsat = 48'sh7FFF_FFFF_FFFF;
    end else if (fsh < -51'sd140737488355328) begin
      fsat = 48'sh8000_0000_0000;
    end else begin
      fsat = fsh[47:0];
    end
    acv  = cv[32] ? 32'(-cv) : cv[31:0];
    ak   = kk[31] ? 32'(-33'(kk)) : kk;
    mode = side_modes[{ai, 1'b0} +: 2];
    skip = ((mode == SIDE_UPPER) && cv[32]) ||
           ((mode == SIDE_LOWER) && !cv[32] && (cv != '0));
    // Energy term: floor(kappa * offset^2 / 2^(2*FRAC_BITS+1)), saturated
    p_full = ({33'b0, mul_p[63:0]} << 32) + {33'b0, eplo};
    mag_f  = p_full[96:33];
    rem_nz = |p_full[32:0];
    mag_n  = {1'b0, mag_f} + {64'b0, rem_nz};
    if (kk[31]) begin
      if (mag_n >= 65'h0_8000_0000_0000_0000) term = 64'sh8000_0000_0000_0000;
      else                                     term = -$signed(mag_n[63:0]);
    end else begin
      if (mag_f >= 64'h7FFF_FFFF_FFFF_FFFF) term = 64'sh7FFF_FFFF_FFFF_FFFF;
      else                                  term = $signed(mag_f);
    end
    esum_add = {esum[63], esum} + {term[63], term};
    if (esum_add[64] != esum_add[63]) begin
      esum_next = esum_add[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      esum_next = esum_add[63:0];
    end
    // Force squared term, saturated
    fmag      = (|ftot[96:80]) ? '1 : ftot[79:16];
    fsum_add  = {1'b0, fsum} + {1'b0, fmag};
    fsum_next = fsum_add[64] ? '1 : fsum_add[63:0];
  end

  // Sequencer: search, divide, blend, force and sums
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      esum      <= '0;
      fsum      <= '0;
    end else begin
      // Hold the result until its transfer
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (do_pop && head.item.is_eval) begin
            now   <= head.item.step_value;
            ai    <= head.item.arg_index;
            argv  <= head.item.arg_value;
            last  <= head.item.last_arg;
            nlast <= nlast_in;
            state <= S_P0;
          end
        end
        S_P0: begin
          prev <= ps_rd;
          if (now <= ps_rd) begin
            pt    <= '0;
            state <= S_TCL;
          end else begin
            state <= S_PN;
          end
        end
        S_PN: begin
          if (now >= ps_rd) begin
            pt    <= nlast;
            state <= S_TCL;
          end else begin
            idx   <= PT_W'(1);
            state <= S_SA;
          end
        end
        S_SA: state <= S_SC;
        S_SC: begin
          if ((now < ps_rd) || (idx == nlast)) begin
            rem   <= now - prev;
            dvs   <= ps_rd - prev;
            quo   <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            prev  <= ps_rd;
            idx   <= idx + PT_W'(1);
            state <= S_SA;
          end
        end
        S_DIV: begin
          rem <= ge ? 32'(r2 - {1'b0, dvs}) : r2[31:0];
          quo <= {quo[14:0], ge};
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) state <= S_TA;
        end
        S_TA: state <= S_TB;
        S_TB: begin
          k0    <= k_rd;
          c0    <= c_rd;
          state <= S_TC;
        end
        S_TC: begin
          k1    <= k_rd;
          c1    <= c_rd;
          state <= S_B1;
        end
        S_B1: state <= S_B2;
        S_B2: begin
          acc   <= mul_p[48:0];
          state <= S_B3;
        end
        S_B3: begin
          kk    <= bsum[47:16];
          state <= S_B4;
        end
        S_B4: begin
          acc   <= mul_p[48:0];
          state <= S_B5;
        end
        S_B5: begin
          aa    <= bsum[47:16];
          state <= S_OFF;
        end
        S_TCL: state <= S_TCL2;
        S_TCL2: begin
          kk    <= k_rd;
          aa    <= c_rd;
          state <= S_OFF;
        end
        S_OFF: begin
          cv    <= 33'(argv) - 33'(aa);
          state <= S_F0;
        end
        S_F0: begin
          if (skip) begin
            appl  <= 1'b0;
            frc   <= '0;
            state <= S_OUT;
          end else begin
            appl  <= 1'b1;
            state <= S_F1;
          end
        end
        S_F1: begin
          frc   <= fsat;
          state <= S_F2;
        end
        S_F2: begin
          sq    <= mul_p[63:0];
          af    <= frc[47] ? 48'(-frc) : frc;
          state <= S_E0;
        end
        S_E0: state <= S_E1;
        S_E1: begin
          eplo  <= mul_p[63:0];
          state <= S_E2;
        end
        S_E2: begin
          esum  <= esum_next;
          state <= S_E3;
        end
        S_E3: begin
          fq0   <= mul_p[63:0];
          state <= S_Q1;
        end
        S_Q1: begin
          fq1   <= mul_p[47:0];
          state <= S_Q2;
        end
        S_Q2: begin
          ftot  <= ({65'b0, mul_p[31:0]} << 64) + ({49'b0, fq1} << 33) + {33'b0, fq0};
          state <= S_Q3;
        end
        S_Q3: begin
          fsum  <= fsum_next;
          state <= S_OUT;
        end
        S_OUT: begin
          if (res_load) begin
            force_res         <= frc;
            applied           <= appl;
            bias_energy       <= esum;
            force_squared_sum <= fsum;
            totals_final      <= last;
            if (last) begin
              esum <= '0;
              fsum <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### test/moving_harmonic_restraint_tb.sv
`timescale 1ns / 1ps

module moving_harmonic_restraint_tb;
  import mhr_pkg::*;

  typedef struct {
    logic               op;
    logic [3:0]         pt;
    logic [2:0]         arg;
    logic [31:0]        step;
    logic signed [31:0] kappa;
    logic signed [31:0] center;
    logic signed [31:0] value;
    logic               last;
  } restraint_item_t;

  typedef struct {
    logic [47:0] force_v;
    logic        applied_v;
    logic [63:0] energy_v;
    logic [63:0] fsq_v;
    logic        final_v;
  } restraint_res_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_index = 1'b0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = 1'b0;
  logic [3:0]         point_index = '0;
  logic [2:0]         arg_index = '0;
  logic [31:0]        step_value = '0;
  logic signed [31:0] kappa_value = '0;
  logic signed [31:0] center_value = '0;
  logic signed [31:0] arg_value = '0;
  logic               last_arg = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [47:0] force_res;
  logic               applied;
  logic signed [63:0] bias_energy;
  logic [63:0]        force_squared_sum;
  logic               totals_final;

  moving_harmonic_restraint dut (.*);

  always #10 clk = ~clk;

  // Shadow state of the restraint
  logic [31:0]        sched_steps [MAX_POINTS];
  longint             sched_kappa [MAX_POINTS*MAX_ARGS];
  longint             sched_center [MAX_POINTS*MAX_ARGS];
  logic signed [63:0] energy_acc = '0;
  logic [63:0]        fsq_acc = '0;
  logic [4:0]         points_cfg = 5'd1;
  logic [15:0]        modes_cfg = '0;

  restraint_res_t expected_forces[$];
  int             errors = 0;
  bit             steady = 1'b0;
  logic [31:0]    base_step;
  logic [31:0]    spacing;

  // Update shadow state for one transfer and work out the result of an evaluate
  function automatic void predict_restraint(input restraint_item_t s);
    int                  n, i;
    longint              kk, aa, cv, wl, fv;
    logic [63:0]         w, s0, s1, now;
    logic [1:0]          mode;
    logic                act;
    logic signed [127:0] k128, c128, p;
    logic [127:0]        q;
    logic signed [64:0]  esum;
    logic [64:0]         usum;
    restraint_res_t      r;
    if (s.op == OP_LOAD) begin
      sched_steps[s.pt] = s.step;
      sched_kappa[s.pt*MAX_ARGS + s.arg] = longint'(s.kappa);
      sched_center[s.pt*MAX_ARGS + s.arg] = longint'(s.center);
      return;
    end
    n = points_cfg;
    if (n < 1) n = 1;
    if (n > MAX_POINTS) n = MAX_POINTS;
    now = {32'd0, s.step};
    if (s.step <= sched_steps[0]) begin
      kk = sched_kappa[s.arg];
      aa = sched_center[s.arg];
    end else if (s.step >= sched_steps[n-1]) begin
      kk = sched_kappa[(n-1)*MAX_ARGS + s.arg];
      aa = sched_center[(n-1)*MAX_ARGS + s.arg];
    end else begin
      for (i = 1; i < n - 1; i++)
        if (s.step < sched_steps[i]) break;
      s0 = {32'd0, sched_steps[i-1]};
      s1 = {32'd0, sched_steps[i]};
      w = ((now - s0) << 16) / (s1 - s0);
      wl = longint'(w);
      kk = (sched_kappa[(i-1)*MAX_ARGS + s.arg] * (65536 - wl)
            + sched_kappa[i*MAX_ARGS + s.arg] * wl) >>> 16;
      aa = (sched_center[(i-1)*MAX_ARGS + s.arg] * (65536 - wl)
            + sched_center[i*MAX_ARGS + s.arg] * wl) >>> 16;
    end
    cv = longint'(s.value) - aa;
    mode = modes_cfg[2*s.arg +: 2];
    act = !((mode == SIDE_UPPER && cv < 0) || (mode == SIDE_LOWER && cv > 0));
    fv = 0;
    if (act) begin
      k128 = kk;
      c128 = cv;
      p = -(k128 * c128) >>> FRAC_BITS;
      if (p > 128'sd140737488355327) fv = 64'sd140737488355327;
      else if (p < -128'sd140737488355328) fv = -64'sd140737488355328;
      else fv = longint'(p);
      // energy term, floor, saturated to signed 64
      p = (k128 * c128 * c128) >>> (2*FRAC_BITS + 1);
      if (p > 128'sh7FFFFFFFFFFFFFFF) p = 128'sh7FFFFFFFFFFFFFFF;
      if (p < -128'sh8000000000000000) p = -128'sh8000000000000000;
      esum = {energy_acc[63], energy_acc} + {p[63], p[63:0]};
      if (esum > 65'sh0_7FFFFFFFFFFFFFFF) energy_acc = 64'h7FFFFFFFFFFFFFFF;
      else if (esum < -65'sh0_8000000000000000) energy_acc = 64'h8000000000000000;
      else energy_acc = esum[63:0];
      // squared force term, saturated unsigned
      k128 = fv;
      q = (k128 * k128) >> FRAC_BITS;
      if (q > 128'hFFFFFFFFFFFFFFFF) q = 128'hFFFFFFFFFFFFFFFF;
      usum = {1'b0, fsq_acc} + {1'b0, q[63:0]};
      fsq_acc = usum[64] ? 64'hFFFFFFFFFFFFFFFF : usum[63:0];
    end
    r.force_v = fv[47:0];
    r.applied_v = act;
    r.energy_v = energy_acc;
    r.fsq_v = fsq_acc;
    r.final_v = s.last;
    expected_forces = {expected_forces, r};
    if (s.last) begin
      energy_acc = '0;
      fsq_acc = '0;
    end
  endfunction

  // Send one item, hold it until the transfer, then predict
  task automatic send_item(input restraint_item_t s);
    bit stalled;
    while (!steady && $urandom_range(0, 99) < 27) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    op = s.op;
    point_index = s.pt;
    arg_index = s.arg;
    step_value = s.step;
    kappa_value = s.kappa;
    center_value = s.center;
    arg_value = s.value;
    last_arg = s.last;
    forever begin
      #1 stalled = in_stall;
      @(posedge clk);
      if (!stalled) break;
      @(negedge clk);
    end
    predict_restraint(s);
  endtask

  // Drop valid and wait until every result is back and the block is quiet
  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    wait (expected_forces.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    if (idx == CFG_NUM_POINTS) points_cfg = data[4:0];
    else modes_cfg = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3: return $urandom();
      default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endcase
  endfunction

  function automatic restraint_item_t make_load(input int p, input int a, input logic [31:0] st);
    restraint_item_t s;
    s.op = OP_LOAD;
    s.pt = 4'(p);
    s.arg = 3'(a);
    s.step = st;
    s.kappa = rand_q16();
    s.center = rand_q16();
    s.value = $urandom();
    s.last = 1'($urandom_range(0, 1));
    return s;
  endfunction

  function automatic restraint_item_t make_eval(input int a, input logic [31:0] st,
                                               input logic [31:0] v, input logic lst);
    restraint_item_t s;
    s.op = OP_EVAL;
    s.pt = 4'($urandom());
    s.arg = 3'(a);
    s.step = st;
    s.kappa = $urandom();
    s.center = $urandom();
    s.value = v;
    s.last = lst;
    return s;
  endfunction

  // Write every point for every argument with an increasing schedule
  task automatic test_fill_schedule;
    base_step = $urandom_range(1000, 100000);
    spacing = $urandom_range(3, 5000);
    for (int p = 0; p < MAX_POINTS; p++)
      for (int a = 0; a < MAX_ARGS; a++)
        send_item(make_load(p, a, base_step + p*spacing));
  endtask

  // Edges of the schedule, field extremes and side handling
  task automatic test_directed;
    restraint_item_t s;
    write_reg(CFG_NUM_POINTS, 16'd4);
    write_reg(CFG_SIDE_MODES, 16'hE4E4);
    send_item(make_eval(0, 32'h0, 32'h0, 1'b0));
    send_item(make_eval(1, 32'hFFFFFFFF, 32'h7FFFFFFF, 1'b0));
    send_item(make_eval(2, base_step + spacing/2, 32'h80000000, 1'b0));
    send_item(make_eval(3, base_step + 2*spacing + 1, 32'h0, 1'b1));
    send_item(make_eval(7, base_step, 32'hFFFFFFFF, 1'b1));
    // extreme force constants and centres to push the sums into saturation
    s = make_load(0, 4, base_step);
    s.kappa = 32'h7FFFFFFF;
    s.center = 32'h80000000;
    send_item(s);
    s = make_load(0, 5, base_step);
    s.kappa = 32'h80000000;
    s.center = 32'h7FFFFFFF;
    send_item(s);
    for (int k = 0; k < 4; k++) begin
      send_item(make_eval(4, 32'h0, 32'h7FFFFFFF, 1'b0));
      send_item(make_eval(5, 32'h0, 32'h80000000, k == 3));
    end
    send_item(make_eval(6, base_step + 3*spacing - 1, 32'h1, 1'b1));
  endtask

  // Mostly schedule-shaped traffic, with stray steps and extremes mixed in
  task automatic test_random(input int count);
    restraint_item_t s;
    int p, n;
    logic [31:0] st;
    for (int k = 0; k < count; k++) begin
      steady = (k >= 500 && k < 800);
      if (k % 250 == 249) begin
        if ($urandom_range(0, 3) == 0) write_reg(CFG_NUM_POINTS, 16'($urandom()));
        else write_reg(CFG_NUM_POINTS, 16'($urandom_range(1, 16)));
        write_reg(CFG_SIDE_MODES, 16'($urandom()));
      end
      if (k == 1000) drain();
      if ($urandom_range(0, 3) == 0) begin
        p = $urandom_range(0, MAX_POINTS - 1);
        st = ($urandom_range(0, 4) == 0) ? $urandom() : base_step + p*spacing;
        send_item(make_load(p, $urandom_range(0, 7), st));
      end else begin
        n = (points_cfg < 1) ? 1 : (points_cfg > 16) ? 16 : points_cfg;
        case ($urandom_range(0, 9))
          0: st = $urandom();
          1: st = sched_steps[$urandom_range(0, n - 1)];
          default: st = base_step + $urandom_range(0, n*spacing);
        endcase
        send_item(make_eval($urandom_range(0, 7), st, rand_q16(),
                            $urandom_range(0, 3) == 0));
      end
    end
  endtask

  // Receiver stalls at random
  always @(negedge clk)
    out_stall <= !steady && ($urandom_range(0, 99) < 27);

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    restraint_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_forces.size() == 0) begin
        $display("%0t: unexpected result force=%h", $time, force_res);
        errors++;
      end else begin
        e = expected_forces.pop_front();
        if (force_res !== e.force_v) begin
          $display("%0t: force exp %h got %h", $time, e.force_v, force_res);
          errors++;
        end
        if (applied !== e.applied_v) begin
          $display("%0t: applied exp %b got %b", $time, e.applied_v, applied);
          errors++;
        end
        if (bias_energy !== e.energy_v) begin
          $display("%0t: energy exp %h got %h", $time, e.energy_v, bias_energy);
          errors++;
        end
        if (force_squared_sum !== e.fsq_v) begin
          $display("%0t: force sq exp %h got %h", $time, e.fsq_v, force_squared_sum);
          errors++;
        end
        if (totals_final !== e.final_v) begin
          $display("%0t: final exp %b got %b", $time, e.final_v, totals_final);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_fill_schedule();
    test_directed();
    test_random(1600);
    drain();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
